// ===== hdl/rasss_pkg.sv =====
// Shared constants and types for the range add/assign/sum store.
package rasss_pkg;

	// Store geometry; BUCKET_SIZE must be a power of two.
	localparam int ELEMENT_COUNT = 4096;
	localparam int BUCKET_SIZE   = 64;
	localparam int BUCKET_COUNT  = (ELEMENT_COUNT + BUCKET_SIZE - 1) / BUCKET_SIZE;
	localparam int EA_W  = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
	localparam int BA_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int OFS_W = $clog2(BUCKET_SIZE);

	localparam int IDX_IN_W = 12;
	localparam int VAL_W    = 30;
	localparam int SUM_W    = 64;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_ASSIGN = 2'd1;
	localparam logic [1:0] ACT_SUM    = 2'd2;

	// One bucket record: running sum and pending marks.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [VAL_W-1:0] asg_val;
		logic             asg_vld;
		logic [SUM_W-1:0] add;
	} bkt_t;

	localparam int BKT_W = $bits(bkt_t);

endpackage

// ===== hdl/rasss_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
module rasss_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/range_add_assign_sum_store.sv =====
// Top level: sequencer for the bucketed range add/assign/sum store.
// Sequence: each edge bucket takes a mark read, an element sweep, a drain and a write back;
//   interior buckets are then swept record by record.
//   The sum strobe is high in the first cycle with busy low; an empty sum range strobes next cycle.
// Throughput: one transaction at a time; busy stays high until it completes.
// Reset: a clearing pass zeroes both RAMs behind busy; no back-pressure.
module range_add_assign_sum_store
	import rasss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          action,
	input  logic [IDX_IN_W-1:0] left_index,
	input  logic [IDX_IN_W-1:0] right_index,
	input  logic [VAL_W-1:0]    value,
	output logic [SUM_W-1:0]    range_sum,
	output logic                sum_valid
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_E_RD, ST_E_MARK, ST_E_SWEEP, ST_E_DRAIN,
		ST_E_WB, ST_I_SWEEP, ST_I_DRAIN
	} state_t;

	state_t state_q;

	// Transaction context
	logic [1:0]       act_q;
	logic [EA_W-1:0]  l_q, r_q;
	logic [VAL_W-1:0] x_q;
	logic [BA_W-1:0]  lb_q, rb_q, cur_b_q, bidx_q;
	logic             second_q;
	logic [SUM_W-1:0] acc_q, rsum_q;
	logic [EA_W:0]    clr_q, eidx_q, eend_q;
	bkt_t             mark_q;

	// Element sweep pipeline
	logic             ev_s1, ev_s2;
	logic [EA_W-1:0]  eidx_s1, eidx_s2;
	logic [SUM_W-1:0] v_s2;
	// Interior sweep pipeline
	logic             bv_s1;
	logic [BA_W-1:0]  bidx_s1;

	// RAM ports
	logic             e_we, b_we;
	logic [EA_W-1:0]  e_waddr, e_raddr;
	logic [SUM_W-1:0] e_wdata, e_rdata;
	logic [BA_W-1:0]  b_waddr, b_raddr;
	bkt_t             b_wdata, b_rdata;
	logic [BKT_W-1:0] b_rdata_raw;

	rasss_ram #(.DEPTH(ELEMENT_COUNT), .WIDTH(SUM_W)) u_elem_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	rasss_ram #(.DEPTH(BUCKET_COUNT), .WIDTH(BKT_W)) u_bkt_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata_raw)
	);
	assign b_rdata = bkt_t'(b_rdata_raw);

	// Index clamp and bucket split for the incoming transaction
	logic [EA_W-1:0] l_c, r_c;
	always_comb begin
		if (32'(left_index) >= ELEMENT_COUNT) l_c = EA_W'(ELEMENT_COUNT - 1);
		else l_c = EA_W'(left_index);
		if (32'(right_index) >= ELEMENT_COUNT) r_c = EA_W'(ELEMENT_COUNT - 1);
		else r_c = EA_W'(right_index);
	end

	logic accept;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Edge bucket element math: s2 applies the command to a settled element
	logic             in_rng_s2;
	logic [SUM_W-1:0] nv_s2, x_ext;
	assign x_ext     = SUM_W'(x_q);
	assign in_rng_s2 = (eidx_s2 >= l_q) && (eidx_s2 <= r_q);
	always_comb begin
		nv_s2 = v_s2;
		if (in_rng_s2) begin
			case (act_q)
				ACT_ADD:    nv_s2 = v_s2 + x_ext;
				ACT_ASSIGN: nv_s2 = x_ext;
				default:    nv_s2 = v_s2;
			endcase
		end
	end

	// Interior bucket update from the record read last cycle
	bkt_t bnew;
	always_comb begin
		bnew = b_rdata;
		case (act_q)
			ACT_ADD: begin
				bnew.add = b_rdata.add + x_ext;
				bnew.sum = b_rdata.sum + (x_ext << OFS_W);
			end
			ACT_ASSIGN: begin
				bnew.asg_vld = 1'b1;
				bnew.asg_val = x_q;
				bnew.add     = '0;
				bnew.sum     = x_ext << OFS_W;
			end
			default: bnew = b_rdata;
		endcase
	end

	// RAM port muxing
	always_comb begin
		e_we    = 1'b0;
		e_waddr = eidx_s2;
		e_wdata = nv_s2;
		e_raddr = eidx_q[EA_W-1:0];
		b_we    = 1'b0;
		b_waddr = bidx_s1;
		b_wdata = bnew;
		b_raddr = (state_q == ST_I_SWEEP) ? bidx_q : cur_b_q;
		if (state_q == ST_CLR) begin
			e_we    = 1'b1;
			e_waddr = clr_q[EA_W-1:0];
			e_wdata = '0;
			b_we    = (clr_q < (EA_W+1)'(BUCKET_COUNT));
			b_waddr = BA_W'(clr_q);
			b_wdata = '0;
		end else begin
			e_we = ev_s2;
			if (state_q == ST_E_WB) begin
				b_we    = 1'b1;
				b_waddr = cur_b_q;
				b_wdata = '{sum: rsum_q, asg_val: '0, asg_vld: 1'b0, add: '0};
			end else begin
				b_we = bv_s1 && (act_q != ACT_SUM);
			end
		end
	end

	// Edge bucket window
	logic [EA_W:0] b_lo, b_hi;
	assign b_lo = (EA_W+1)'(cur_b_q) << OFS_W;
	assign b_hi = ((b_lo + (EA_W+1)'(BUCKET_SIZE)) > (EA_W+1)'(ELEMENT_COUNT))
		? (EA_W+1)'(ELEMENT_COUNT) : (b_lo + (EA_W+1)'(BUCKET_SIZE));

	// Pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= 1'b0;
			ev_s2 <= 1'b0;
			bv_s1 <= 1'b0;
		end else begin
			ev_s1 <= (state_q == ST_E_SWEEP);
			ev_s2 <= ev_s1;
			bv_s1 <= (state_q == ST_I_SWEEP);
		end
	end

	function automatic logic [SUM_W-1:0] x_ext_mark(input logic [VAL_W-1:0] v);
		return SUM_W'(v);
	endfunction

	always_ff @(posedge clk) begin
		eidx_s1 <= eidx_q[EA_W-1:0];
		eidx_s2 <= eidx_s1;
		bidx_s1 <= bidx_q;
		// settle: pending assign first, then pending add
		v_s2 <= (mark_q.asg_vld ? x_ext_mark(mark_q.asg_val) : e_rdata) + mark_q.add;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			sum_valid <= 1'b0;
			range_sum <= '0;
			act_q     <= ACT_ADD;
			l_q       <= '0;
			r_q       <= '0;
			x_q       <= '0;
			lb_q      <= '0;
			rb_q      <= '0;
			cur_b_q   <= '0;
			bidx_q    <= '0;
			second_q  <= 1'b0;
			acc_q     <= '0;
			rsum_q    <= '0;
			eidx_q    <= '0;
			eend_q    <= '0;
			mark_q    <= '0;
		end else begin
			sum_valid <= 1'b0;
			if (ev_s2) begin
				rsum_q <= rsum_q + nv_s2;
				if (act_q == ACT_SUM && in_rng_s2) acc_q <= acc_q + v_s2;
			end
			if (bv_s1 && act_q == ACT_SUM) acc_q <= acc_q + b_rdata.sum;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (EA_W+1)'(ELEMENT_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && action <= ACT_SUM) begin
						if (l_c > r_c) begin
							if (action == ACT_SUM) begin
								range_sum <= '0;
								sum_valid <= 1'b1;
							end
						end else begin
							act_q    <= action;
							l_q      <= l_c;
							r_q      <= r_c;
							x_q      <= value;
							lb_q     <= BA_W'(l_c >> OFS_W);
							rb_q     <= BA_W'(r_c >> OFS_W);
							cur_b_q  <= BA_W'(l_c >> OFS_W);
							second_q <= (BA_W'(l_c >> OFS_W) != BA_W'(r_c >> OFS_W));
							acc_q    <= '0;
							state_q  <= ST_E_RD;
						end
					end
				end
				ST_E_RD: state_q <= ST_E_MARK;
				ST_E_MARK: begin
					mark_q  <= b_rdata;
					eidx_q  <= b_lo;
					eend_q  <= b_hi;
					rsum_q  <= '0;
					state_q <= ST_E_SWEEP;
				end
				ST_E_SWEEP: begin
					eidx_q <= eidx_q + 1'b1;
					if (eidx_q + 1'b1 == eend_q) state_q <= ST_E_DRAIN;
				end
				ST_E_DRAIN: begin
					if (!ev_s1 && !ev_s2) state_q <= ST_E_WB;
				end
				ST_E_WB: begin
					if (second_q) begin
						second_q <= 1'b0;
						cur_b_q  <= rb_q;
						state_q  <= ST_E_RD;
					end else if ((BA_W+1)'(rb_q) > (BA_W+1)'(lb_q) + (BA_W+1)'(1)) begin
						// one extra bit so the last bucket does not wrap to zero
						bidx_q  <= lb_q + 1'b1;
						state_q <= ST_I_SWEEP;
					end else begin
						if (act_q == ACT_SUM) begin
							range_sum <= acc_q;
							sum_valid <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_I_SWEEP: begin
					bidx_q <= bidx_q + 1'b1;
					if (bidx_q + 1'b1 == rb_q) state_q <= ST_I_DRAIN;
				end
				ST_I_DRAIN: begin
					if (!bv_s1) begin
						if (act_q == ACT_SUM) begin
							range_sum <= acc_q;
							sum_valid <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/tb_range_add_assign_sum_store.sv =====
// Testbench for the range add/assign/sum store: directed table, random commands, sum checks.
module tb_range_add_assign_sum_store;
	import rasss_pkg::*;

	localparam int  N_RANDOM    = 1000;
	localparam int  CALM_TAIL   = 100;       // last random commands go without gaps
	localparam int  DRAIN_WAIT  = 300;       // longer than the slowest command
	localparam int  CYCLE_LIMIT = 1000000;
	localparam logic [1:0] ACT_NONE = 2'd3;  // unused code, block ignores it

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          action;
	logic [IDX_IN_W-1:0] left_index;
	logic [IDX_IN_W-1:0] right_index;
	logic [VAL_W-1:0]    value;
	logic [SUM_W-1:0]    range_sum;
	logic                sum_valid;

	// Directed rows may carry a sum typed in by hand; it then replaces the predicted one.
	logic                fixed_en;
	logic [SUM_W-1:0]    fixed_sum;

	int                  err_count;
	int                  cycle_count;
	logic [SUM_W-1:0]    sums_due[$];

	// Predictor state: elements plus per-bucket sum and pending marks.
	logic [SUM_W-1:0]    elem[ELEMENT_COUNT];
	logic [SUM_W-1:0]    bkt_sum[BUCKET_COUNT];
	logic [VAL_W-1:0]    bkt_asg_val[BUCKET_COUNT];
	logic                bkt_asg_vld[BUCKET_COUNT];
	logic [SUM_W-1:0]    bkt_add[BUCKET_COUNT];

	range_add_assign_sum_store u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.left_index (left_index),
		.right_index(right_index),
		.value      (value),
		.range_sum  (range_sum),
		.sum_valid  (sum_valid)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// One past the last element of bucket b (the last bucket may be partial).
	function automatic int bkt_limit(input int b);
		int hi;
		hi = (b + 1) * BUCKET_SIZE;
		return (hi > ELEMENT_COUNT) ? ELEMENT_COUNT : hi;
	endfunction

	// Push a bucket's pending marks down into its elements: assign first, then add.
	function automatic void flush_marks(input int b);
		int i;
		if (bkt_asg_vld[b]) begin
			for (i = b * BUCKET_SIZE; i < bkt_limit(b); i++)
				elem[i] = SUM_W'(bkt_asg_val[b]);
			bkt_asg_vld[b] = 1'b0;
			bkt_asg_val[b] = '0;
		end
		if (bkt_add[b] != 0) begin
			for (i = b * BUCKET_SIZE; i < bkt_limit(b); i++)
				elem[i] += bkt_add[b];
			bkt_add[b] = '0;
		end
	endfunction

	function automatic void rebuild_sum(input int b);
		int i;
		logic [SUM_W-1:0] s;
		s = '0;
		for (i = b * BUCKET_SIZE; i < bkt_limit(b); i++)
			s += elem[i];
		bkt_sum[b] = s;
	endfunction

	// Touch elements lo..hi of one flushed edge bucket.
	function automatic void edge_touch(input logic [1:0] act, input int lo, input int hi,
			input logic [SUM_W-1:0] x, inout logic [SUM_W-1:0] acc);
		int i;
		for (i = lo; i <= hi; i++) begin
			case (act)
				ACT_ADD:    elem[i] += x;
				ACT_ASSIGN: elem[i] = x;
				default:    acc += elem[i];
			endcase
		end
	endfunction

	// Apply one accepted command; returns 1 with the range sum when a result is due.
	function automatic bit run_command(input logic [1:0] act, input logic [IDX_IN_W-1:0] li,
			input logic [IDX_IN_W-1:0] ri, input logic [VAL_W-1:0] v,
			output logic [SUM_W-1:0] acc);
		int l, r, lb, rb, b;
		logic [SUM_W-1:0] x;
		acc = '0;
		l = (int'(li) >= ELEMENT_COUNT) ? ELEMENT_COUNT - 1 : int'(li);
		r = (int'(ri) >= ELEMENT_COUNT) ? ELEMENT_COUNT - 1 : int'(ri);
		x = SUM_W'(v);
		if (act == ACT_NONE)
			return 0;
		if (l > r)
			return act == ACT_SUM;
		lb = l / BUCKET_SIZE;
		rb = r / BUCKET_SIZE;
		flush_marks(lb);
		flush_marks(rb);
		if (lb == rb) begin
			edge_touch(act, l, r, x, acc);
		end else begin
			edge_touch(act, l, bkt_limit(lb) - 1, x, acc);
			edge_touch(act, rb * BUCKET_SIZE, r, x, acc);
			for (b = lb + 1; b < rb; b++) begin
				case (act)
					ACT_ADD: begin
						bkt_add[b] += x;
						bkt_sum[b] += x * BUCKET_SIZE;
					end
					ACT_ASSIGN: begin
						bkt_asg_vld[b] = 1'b1;
						bkt_asg_val[b] = v;
						bkt_add[b]     = '0;
						bkt_sum[b]     = x * BUCKET_SIZE;
					end
					default: acc += bkt_sum[b];
				endcase
			end
		end
		if (act == ACT_SUM)
			return 1;
		rebuild_sum(lb);
		if (rb != lb)
			rebuild_sum(rb);
		return 0;
	endfunction

	// Scoreboard: check a strobed sum first, then predict from a transaction taken this edge.
	always @(posedge clk) begin : sum_check
		logic [SUM_W-1:0] want;
		logic [SUM_W-1:0] got;
		if (sum_valid) begin
			if (sums_due.size() == 0) begin
				report_mismatch($sformatf("unexpected range_sum %h", range_sum));
			end else begin
				want = sums_due.pop_front();
				if (range_sum !== want)
					report_mismatch($sformatf("range_sum %h, want %h", range_sum, want));
			end
		end
		if (arst_n && start && !busy) begin
			if (run_command(action, left_index, right_index, value, got))
				sums_due.push_back(fixed_en ? fixed_sum : got);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("range_add_assign_sum_store regression: fail");
			$finish;
		end
	end

	typedef struct {
		logic [1:0]          act;
		logic [IDX_IN_W-1:0] li;
		logic [IDX_IN_W-1:0] ri;
		logic [VAL_W-1:0]    v;
		bit                  typed;
		logic [SUM_W-1:0]    sum;
	} cmd_row_t;

	// Directed table: empty store, whole-range extremes, edges, assign of zero, odd cases.
	cmd_row_t dir_rows[] = '{
		'{ACT_SUM,    12'd0,    12'd4095, 30'd0,          1, 64'd0},          // fresh store
		'{ACT_SUM,    12'd0,    12'd0,    30'h3FFFFFFF,   1, 64'd0},
		'{ACT_SUM,    12'd10,   12'd5,    30'd0,          1, 64'd0},          // left above right
		'{ACT_NONE,   12'hFFF,  12'h000,  30'h3FFFFFFF,   0, 64'd0},          // ignored code
		'{ACT_ASSIGN, 12'd0,    12'd4095, 30'h3FFFFFFF,   0, 64'd0},
		'{ACT_SUM,    12'd0,    12'd4095, 30'd0,          1, 64'h3FFFFFFF000},
		'{ACT_SUM,    12'd4095, 12'd4095, 30'd0,          1, 64'h3FFFFFFF},
		'{ACT_ADD,    12'd0,    12'd4095, 30'h3FFFFFFF,   0, 64'd0},
		'{ACT_SUM,    12'd63,   12'd64,   30'd0,          0, 64'd0},          // bucket boundary
		'{ACT_ASSIGN, 12'd100,  12'd300,  30'd0,          0, 64'd0},          // assign of zero
		'{ACT_SUM,    12'd0,    12'd4095, 30'd0,          0, 64'd0},
		'{ACT_ADD,    12'd128,  12'd1000, 30'd1,          0, 64'd0},
		'{ACT_SUM,    12'd100,  12'd300,  30'd0,          0, 64'd0},
		'{ACT_ADD,    12'd5,    12'd2,    30'h3FFFFFFF,   0, 64'd0},          // empty add
		'{ACT_ASSIGN, 12'd4000, 12'd3999, 30'h1,          0, 64'd0},          // empty assign
		'{ACT_ASSIGN, 12'd64,   12'd127,  30'h2AAAAAAA,   0, 64'd0},          // exactly one bucket
		'{ACT_ADD,    12'd0,    12'd0,    30'h15555555,   0, 64'd0},
		'{ACT_SUM,    12'd0,    12'd200,  30'd0,          0, 64'd0},
		'{ACT_SUM,    12'd4032, 12'd4095, 30'd0,          0, 64'd0},          // last bucket
		'{ACT_NONE,   12'd0,    12'd4095, 30'd0,          0, 64'd0},
		'{ACT_SUM,    12'd0,    12'd4095, 30'd0,          0, 64'd0}
	};

	// Put one transaction on the ports, hold it until taken, then maybe pause.
	task automatic issue(input cmd_row_t c, input bit may_idle);
		start       <= 1'b1;
		action      <= c.act;
		left_index  <= c.li;
		right_index <= c.ri;
		value       <= c.v;
		fixed_en    <= c.typed;
		fixed_sum   <= c.sum;
		do @(posedge clk); while (busy);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	function automatic cmd_row_t random_cmd();
		cmd_row_t c;
		int k;
		int base;
		c.typed = 0;
		c.sum   = '0;
		k = $urandom_range(0, 99);
		c.act = (k < 3) ? ACT_NONE : 2'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0: c.v = 30'($urandom);
			1: c.v = 30'($urandom_range(0, 15));
			2: c.v = ($urandom_range(0, 1) != 0) ? 30'h3FFFFFFF : 30'd0;
			default: c.v = 30'($urandom_range(0, 1000000));
		endcase
		k = $urandom_range(0, 99);
		if (k < 35) begin
			// inside one bucket
			base = $urandom_range(0, BUCKET_COUNT - 1) * BUCKET_SIZE;
			c.li = 12'(base + $urandom_range(0, BUCKET_SIZE - 1));
			c.ri = 12'(base + $urandom_range(0, BUCKET_SIZE - 1));
		end else if (k < 45) begin
			// aligned to bucket edges
			c.li = 12'($urandom_range(0, BUCKET_COUNT - 1) * BUCKET_SIZE);
			c.ri = 12'($urandom_range(0, BUCKET_COUNT - 1) * BUCKET_SIZE + BUCKET_SIZE - 1);
		end else begin
			c.li = 12'($urandom);
			c.ri = 12'($urandom);
		end
		// mostly ordered ranges, a few left above right
		if (c.li > c.ri && $urandom_range(0, 9) != 0) begin
			base = c.li;
			c.li = c.ri;
			c.ri = 12'(base);
		end
		return c;
	endfunction

	initial begin
		int i;
		start       = 1'b0;
		action      = ACT_ADD;
		left_index  = '0;
		right_index = '0;
		value       = '0;
		fixed_en    = 1'b0;
		fixed_sum   = '0;
		err_count   = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		for (i = 0; i < ELEMENT_COUNT; i++)
			elem[i] = '0;
		for (i = 0; i < BUCKET_COUNT; i++) begin
			bkt_sum[i]     = '0;
			bkt_asg_val[i] = '0;
			bkt_asg_vld[i] = 1'b0;
			bkt_add[i]     = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Block clears its RAMs behind busy; the handshake covers that wait.
		foreach (dir_rows[j])
			issue(dir_rows[j], 1);

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// drain fully once mid-run
				start <= 1'b0;
				while (sums_due.size() != 0) @(posedge clk);
				repeat (DRAIN_WAIT) @(posedge clk);
			end
			issue(random_cmd(), i < N_RANDOM - CALM_TAIL);
		end
		start <= 1'b0;

		while (sums_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sums_due.size() != 0)
			report_mismatch("sums still outstanding");
		if (err_count == 0)
			$display("range_add_assign_sum_store regression: pass");
		else
			$display("range_add_assign_sum_store regression: fail");
		$finish;
	end

endmodule
